// ===== hdl/dpr_pkg.sv =====
// Shared types and constants for the DMA PCM8 playback resampler.
`timescale 1ns / 1ps

package dpr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 17;
    localparam int ACTION_W = 2;
    localparam int TC_W     = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_ALL_ONES = {COUNT_W{1'b1}};
    localparam logic [BYTE_W-1:0]  BYTE_BIAS      = 8'h80;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_CONSTANT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 1'b1;

    // Action codes as seen on the input channel
    localparam logic [ACTION_W-1:0] ACT_SLOT  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FLAGS = 2'd2;

    // Decoded operation carried through the queue
    typedef enum logic [1:0] {
        OP_SLOT  = 2'd0,
        OP_START = 2'd1,
        OP_FLAGS = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic                       frame_start;
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
        logic [BYTE_W-1:0]          dma_byte;
        logic [COUNT_W-1:0]         length;
        logic                       auto_init;
        logic                       speaker_on;
        logic                       paused;
    } item_t;

    // Queue handshake between front and back
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

endpackage

// ===== hdl/dma_pcm8_playback_resampler.sv =====
// An accepted word is queued, then moves into the output register when popped.
// Throughput: one word per cycle while m_ready stays high; the back end retires one
// queued word per cycle, with a combinational phase accumulator and mix adder.
// The two-entry queue lets the input side keep accepting while a result waits.
// Reset (aresetn low, synchronous) empties the queue and clears all playback state;
// time_constant resets to 0 and block_size to 1.
`timescale 1ns / 1ps

module dma_pcm8_playback_resampler #(
    parameter int FRAME_MAX       = 4096,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [dpr_pkg::ACTION_W-1:0]         s_action,
    input  logic                                 s_frame_start,
    input  logic signed [dpr_pkg::SAMPLE_W-1:0]  s_left_in,
    input  logic signed [dpr_pkg::SAMPLE_W-1:0]  s_right_in,
    input  logic [dpr_pkg::BYTE_W-1:0]           s_dma_byte,
    input  logic [dpr_pkg::COUNT_W-1:0]          s_length,
    input  logic                                 s_auto_init,
    input  logic                                 s_speaker_on,
    input  logic                                 s_paused,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dpr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dpr_pkg::COUNT_W-1:0]          cfg_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [dpr_pkg::SAMPLE_W-1:0]  m_left_out,
    output logic signed [dpr_pkg::SAMPLE_W-1:0]  m_right_out,
    output logic                                 m_byte_taken,
    output logic                                 m_irq
);
    import dpr_pkg::*;

    logic    q_full;
    logic    q_push;
    item_t   q_item;
    logic    q_pop;
    q_head_t q_head;

    dpr_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_frame_start (s_frame_start),
        .s_left_in     (s_left_in),
        .s_right_in    (s_right_in),
        .s_dma_byte    (s_dma_byte),
        .s_length      (s_length),
        .s_auto_init   (s_auto_init),
        .s_speaker_on  (s_speaker_on),
        .s_paused      (s_paused),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_item)
    );

    dpr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head)
    );

    dpr_back #(
        .FRAME_MAX       (FRAME_MAX),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (q_head),
        .pop          (q_pop),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_left_out   (m_left_out),
        .m_right_out  (m_right_out),
        .m_byte_taken (m_byte_taken),
        .m_irq        (m_irq)
    );

endmodule

// ===== hdl/dpr_front.sv =====
// Front end: accepts input words and classifies them into queue items.
`timescale 1ns / 1ps

module dpr_front (
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [dpr_pkg::ACTION_W-1:0]         s_action,
    input  logic                                 s_frame_start,
    input  logic signed [dpr_pkg::SAMPLE_W-1:0]  s_left_in,
    input  logic signed [dpr_pkg::SAMPLE_W-1:0]  s_right_in,
    input  logic [dpr_pkg::BYTE_W-1:0]           s_dma_byte,
    input  logic [dpr_pkg::COUNT_W-1:0]          s_length,
    input  logic                                 s_auto_init,
    input  logic                                 s_speaker_on,
    input  logic                                 s_paused,
    input  logic                                 q_full,
    output logic                                 q_push,
    output dpr_pkg::item_t                       q_item
);
    import dpr_pkg::*;

    op_t op;

    // Decode the action code
    always_comb begin
        unique case (s_action)
            ACT_SLOT:  op = OP_SLOT;
            ACT_START: op = OP_START;
            ACT_FLAGS: op = OP_FLAGS;
            default:   op = OP_NOP;
        endcase
    end

    // Accept whenever the queue has room
    assign s_ready = ~q_full;
    assign q_push  = s_valid & ~q_full;

    // Frame start only matters on sample slots
    always_comb begin
        q_item             = '0;
        q_item.op          = op;
        q_item.left_in     = s_left_in;
        q_item.right_in    = s_right_in;
        q_item.frame_start = (op == OP_SLOT) & s_frame_start;
        q_item.dma_byte    = s_dma_byte;
        q_item.length      = s_length;
        q_item.auto_init   = s_auto_init;
        q_item.speaker_on  = s_speaker_on;
        q_item.paused      = s_paused;
    end

endmodule

// ===== hdl/dpr_queue.sv =====
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps

module dpr_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  dpr_pkg::item_t   push_item,
    output logic             full,
    input  logic             pop,
    output dpr_pkg::q_head_t head
);
    import dpr_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign do_push = push & ~full;
    assign do_pop  = pop & (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/dpr_back.sv =====
// Back end: playback state, phase accumulator, mixing and the output register.
`timescale 1ns / 1ps

module dpr_back #(
    parameter int FRAME_MAX       = 4096,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  dpr_pkg::q_head_t                     head,
    output logic                                 pop,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dpr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dpr_pkg::COUNT_W-1:0]          cfg_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [dpr_pkg::SAMPLE_W-1:0]  m_left_out,
    output logic signed [dpr_pkg::SAMPLE_W-1:0]  m_right_out,
    output logic                                 m_byte_taken,
    output logic                                 m_irq
);
    import dpr_pkg::*;

    localparam int POS_W   = $clog2(FRAME_MAX + 1);
    localparam int INT_W   = (POS_W + 1 > 15) ? POS_W + 1 : 15;
    localparam int PHASE_W = INT_W + PHASE_FRAC_BITS;
    localparam int CMP_W   = (POS_W > COUNT_W) ? POS_W : COUNT_W;
    localparam int TC_N    = 2 ** TC_W;

    localparam logic [POS_W-1:0]          POS_MAX   = POS_W'(FRAME_MAX);
    localparam logic signed [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;

    typedef logic signed [PHASE_W-1:0] delta_arr_t [TC_N];

    // Phase change on a slot that takes a byte: one sample period minus the step
    function automatic delta_arr_t make_deltas();
        delta_arr_t        t;
        longint unsigned   n;
        for (int i = 0; i < TC_N; i++) begin
            n    = (longint'(44100) * longint'(TC_N - i)) << PHASE_FRAC_BITS;
            t[i] = PHASE_W'((longint'(1) << PHASE_FRAC_BITS) - longint'(n / 1000000));
        end
        return t;
    endfunction

    localparam delta_arr_t DELTA_TAB = make_deltas();

    // Configuration
    logic [TC_W-1:0]    tc_reg;
    logic [COUNT_W-1:0] block_size_reg;

    // Playback state
    logic [COUNT_W-1:0]         remaining_reg, remaining_next;
    logic                       active_reg, active_next;
    logic                       auto_reg, auto_next;
    logic                       speaker_reg, speaker_next;
    logic                       halted_reg, halted_next;
    logic                       frame_en_reg, frame_en_next;
    logic [COUNT_W-1:0]         frame_limit_reg, frame_limit_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic signed [PHASE_W-1:0]  phase_reg, phase_next;
    logic signed [SAMPLE_W-1:0] held_reg, held_next;

    // Output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] left_reg, left_next;
    logic signed [SAMPLE_W-1:0] right_reg, right_next;
    logic                       taken_reg, taken_next;
    logic                       irq_reg, irq_next;

    // Slot working values
    item_t                      it;
    logic                       slot_en;
    logic [COUNT_W-1:0]         slot_limit;
    logic [POS_W-1:0]           slot_pos;
    logic signed [PHASE_W-1:0]  slot_phase;
    logic signed [SAMPLE_W-1:0] slot_held;
    logic                       slot_act;
    logic                       slot_take;
    logic [COUNT_W-1:0]         count_dec;

    assign it  = head.item;
    assign pop = head.valid & (~out_valid_reg | m_ready);

    assign cfg_ready    = 1'b1;
    assign m_valid      = out_valid_reg;
    assign m_left_out   = left_reg;
    assign m_right_out  = right_reg;
    assign m_byte_taken = taken_reg;
    assign m_irq        = irq_reg;

    // Frame start overrides the per-frame state for this slot
    always_comb begin
        if (it.frame_start) begin
            slot_en    = speaker_reg & ~halted_reg & active_reg;
            slot_limit = auto_reg ? COUNT_ALL_ONES : remaining_reg;
            slot_pos   = '0;
            slot_phase = '0;
            slot_held  = '0;
        end else begin
            slot_en    = frame_en_reg;
            slot_limit = frame_limit_reg;
            slot_pos   = pos_reg;
            slot_phase = phase_reg;
            slot_held  = held_reg;
        end
        slot_act  = slot_en & (CMP_W'(slot_pos) < CMP_W'(slot_limit)) & (slot_pos < POS_MAX);
        slot_take = slot_act & ~slot_phase[PHASE_W-1];
        count_dec = remaining_reg - COUNT_W'(1);
    end

    // Execute the item at the head of the queue
    always_comb begin
        remaining_next   = remaining_reg;
        active_next      = active_reg;
        auto_next        = auto_reg;
        speaker_next     = speaker_reg;
        halted_next      = halted_reg;
        frame_en_next    = frame_en_reg;
        frame_limit_next = frame_limit_reg;
        pos_next         = pos_reg;
        phase_next       = phase_reg;
        held_next        = held_reg;
        left_next        = it.left_in;
        right_next       = it.right_in;
        taken_next       = 1'b0;
        irq_next         = 1'b0;

        unique case (it.op)
            OP_START: begin
                remaining_next = it.length;
                auto_next      = it.auto_init;
                active_next    = 1'b1;
            end
            OP_FLAGS: begin
                speaker_next = it.speaker_on;
                halted_next  = it.paused;
            end
            OP_SLOT: begin
                frame_en_next    = slot_en;
                frame_limit_next = slot_limit;
                phase_next       = slot_phase;
                held_next        = slot_held;
                if (slot_take) begin
                    held_next  = {~it.dma_byte[BYTE_W-1], it.dma_byte[BYTE_W-2:0],
                                  {(SAMPLE_W-BYTE_W){1'b0}}};
                    taken_next = 1'b1;
                    remaining_next = count_dec;
                    if (count_dec == '0) begin
                        irq_next = 1'b1;
                        if (auto_reg) begin
                            remaining_next = block_size_reg;
                        end else begin
                            active_next = 1'b0;
                        end
                    end
                end
                if (slot_act) begin
                    phase_next = slot_phase + (slot_take ? DELTA_TAB[tc_reg] : PHASE_ONE);
                    left_next  = it.left_in + held_next;
                    right_next = it.right_in + held_next;
                end
                pos_next = (slot_pos < POS_MAX) ? slot_pos + POS_W'(1) : slot_pos;
            end
            default: begin
                // no-op word: pass the mix through
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tc_reg          <= '0;
            block_size_reg  <= COUNT_W'(1);
            remaining_reg   <= '0;
            active_reg      <= 1'b0;
            auto_reg        <= 1'b0;
            speaker_reg     <= 1'b0;
            halted_reg      <= 1'b0;
            frame_en_reg    <= 1'b0;
            frame_limit_reg <= '0;
            pos_reg         <= '0;
            phase_reg       <= '0;
            held_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_TIME_CONSTANT) begin
                    tc_reg <= cfg_data[TC_W-1:0];
                end else if (cfg_index == CFG_BLOCK_SIZE) begin
                    block_size_reg <= cfg_data;
                end
            end
            if (pop) begin
                remaining_reg   <= remaining_next;
                active_reg      <= active_next;
                auto_reg        <= auto_next;
                speaker_reg     <= speaker_next;
                halted_reg      <= halted_next;
                frame_en_reg    <= frame_en_next;
                frame_limit_reg <= frame_limit_next;
                pos_reg         <= pos_next;
                phase_reg       <= phase_next;
                held_reg        <= held_next;
            end
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            left_reg  <= left_next;
            right_reg <= right_next;
            taken_reg <= taken_next;
            irq_reg   <= irq_next;
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the DMA PCM8 playback resampler: directed and random words.
`timescale 1ns / 1ps

module tb_top;
    import dpr_pkg::*;

    localparam int FRAME_LEN  = 4096;
    localparam int PHASE_BITS = 16;
    localparam int HOLD_LEN   = 200;
    localparam int RUN_LIMIT  = 400000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       taken;
        logic                       irq;
    } mix_result_t;

    // Clock, reset and DUT input ports, all known from time zero
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [ACTION_W-1:0] s_action = '0;
    logic s_frame_start = 1'b0;
    logic signed [SAMPLE_W-1:0] s_left_in = '0;
    logic signed [SAMPLE_W-1:0] s_right_in = '0;
    logic [BYTE_W-1:0] s_dma_byte = '0;
    logic [COUNT_W-1:0] s_length = '0;
    logic s_auto_init = 1'b0;
    logic s_speaker_on = 1'b0;
    logic s_paused = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COUNT_W-1:0] cfg_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_left_out;
    logic signed [SAMPLE_W-1:0] m_right_out;
    logic m_byte_taken;
    logic m_irq;

    // Words waiting to be sent and mix results waiting to arrive
    item_t       pending_words[$];
    mix_result_t expected_mix[$];

    // Traffic shaping, changed by the sequencer at the falling edge
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    bit  tx_pause = 1'b0;
    int  hold_token = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  mismatches = 0;
    int  cycle_count = 0;

    // Shadow of the playback engine
    logic [TC_W-1:0]     tc_reg = '0;
    logic [COUNT_W-1:0]  blk_reg = 17'd1;
    logic [COUNT_W-1:0]  cnt_left = '0;
    logic                playing = 1'b0;
    logic                auto_mode = 1'b0;
    logic                spk_on = 1'b0;
    logic                halted = 1'b0;
    logic                frame_live = 1'b0;
    logic [COUNT_W-1:0]  frame_cap = '0;
    logic [12:0]         frame_pos = '0;
    logic signed [31:0]  phase = '0;
    logic signed [SAMPLE_W-1:0] held = '0;

    dma_pcm8_playback_resampler #(
        .FRAME_MAX(FRAME_LEN),
        .PHASE_FRAC_BITS(PHASE_BITS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_frame_start(s_frame_start),
        .s_left_in(s_left_in),
        .s_right_in(s_right_in),
        .s_dma_byte(s_dma_byte),
        .s_length(s_length),
        .s_auto_init(s_auto_init),
        .s_speaker_on(s_speaker_on),
        .s_paused(s_paused),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_left_out(m_left_out),
        .m_right_out(m_right_out),
        .m_byte_taken(m_byte_taken),
        .m_irq(m_irq)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advance the shadow engine by one accepted word and return its mix result
    function automatic mix_result_t predict_mix(input item_t w);
        mix_result_t r;
        longint step;
        r.left = w.left_in;
        r.right = w.right_in;
        r.taken = 1'b0;
        r.irq = 1'b0;
        step = (longint'(44100) * (256 - int'(tc_reg)) * (longint'(1) << PHASE_BITS)) / 1000000;
        case (w.op)
            OP_START: begin
                cnt_left = w.length;
                auto_mode = w.auto_init;
                playing = 1'b1;
            end
            OP_FLAGS: begin
                spk_on = w.speaker_on;
                halted = w.paused;
            end
            OP_SLOT: begin
                // Frame start restarts phase and latches the flags and the limit
                if (w.frame_start) begin
                    phase = '0;
                    held = '0;
                    frame_pos = '0;
                    frame_live = spk_on && !halted && playing;
                    frame_cap = auto_mode ? COUNT_ALL_ONES : cnt_left;
                end
                if (frame_live && COUNT_W'(frame_pos) < frame_cap &&
                    32'(frame_pos) < FRAME_LEN) begin
                    if (phase >= 0) begin
                        phase = 32'(phase - step);
                        held = {w.dma_byte - BYTE_BIAS, 8'h00};
                        r.taken = 1'b1;
                        cnt_left = cnt_left - COUNT_W'(1);
                        // Count hit zero: reload in auto-init, stop otherwise
                        if (cnt_left == '0) begin
                            if (auto_mode)
                                cnt_left = blk_reg;
                            else
                                playing = 1'b0;
                            r.irq = 1'b1;
                        end
                    end
                    phase = phase + (32'sd1 <<< PHASE_BITS);
                    r.left = w.left_in + held;
                    r.right = w.right_in + held;
                end
                if (32'(frame_pos) < FRAME_LEN)
                    frame_pos = frame_pos + 13'd1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Fill every field at random, then let the caller pin what matters
    function automatic item_t rand_word(input op_t op);
        item_t w;
        w.op = op;
        w.frame_start = 1'($urandom_range(1));
        w.left_in = SAMPLE_W'($urandom);
        w.right_in = SAMPLE_W'($urandom);
        w.dma_byte = BYTE_W'($urandom);
        w.length = COUNT_W'($urandom);
        w.auto_init = 1'($urandom_range(1));
        w.speaker_on = 1'($urandom_range(1));
        w.paused = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic item_t slot_word(input logic fs, input logic [15:0] l,
                                        input logic [15:0] r, input logic [7:0] b);
        item_t w;
        w = rand_word(OP_SLOT);
        w.frame_start = fs;
        w.left_in = l;
        w.right_in = r;
        w.dma_byte = b;
        return w;
    endfunction

    function automatic item_t start_word(input logic [COUNT_W-1:0] len, input logic ai);
        item_t w;
        w = rand_word(OP_START);
        w.length = len;
        w.auto_init = ai;
        return w;
    endfunction

    function automatic item_t flags_word(input logic spk, input logic pause);
        item_t w;
        w = rand_word(OP_FLAGS);
        w.speaker_on = spk;
        w.paused = pause;
        return w;
    endfunction

    // Mostly short transfers, some long ones, the edges now and then
    function automatic logic [COUNT_W-1:0] pick_length();
        int c;
        c = $urandom_range(99);
        if (c < 70)
            return COUNT_W'($urandom_range(1, 16));
        else if (c < 85)
            return COUNT_W'($urandom_range(17, 300));
        else if (c < 95)
            return COUNT_W'($urandom_range(1, 65536));
        else if (c < 98)
            return 17'h10000;
        else
            return '0;
    endfunction

    // Queue playback sessions with random content, plus some noise words
    task automatic gen_traffic(input int n);
        int made;
        int frames;
        int slots;
        made = 0;
        while (made < n) begin
            if ($urandom_range(99) < 80) begin
                pending_words.push_back(flags_word($urandom_range(9) != 0,
                                                   $urandom_range(7) == 0));
                pending_words.push_back(start_word(pick_length(),
                                                   1'($urandom_range(1))));
                made += 2;
                frames = $urandom_range(1, 3);
                repeat (frames) begin
                    pending_words.push_back(slot_word(1'b1, 16'($urandom), 16'($urandom),
                                                      8'($urandom)));
                    made++;
                    slots = $urandom_range(1, 24);
                    repeat (slots) begin
                        // Drop in a mid-frame flag or start change now and then
                        if ($urandom_range(99) < 4)
                            pending_words.push_back(rand_word(op_t'($urandom_range(1, 2))));
                        else
                            pending_words.push_back(slot_word(1'b0, 16'($urandom),
                                                              16'($urandom), 8'($urandom)));
                        made++;
                    end
                end
            end else begin
                pending_words.push_back(rand_word(op_t'($urandom_range(3))));
                made++;
            end
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_mix.size() != 0);
    endtask

    // Sender: offer the next word once the current one is gone
    always @(posedge aclk) begin : tx_side
        item_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_words.size() != 0 && !tx_pause &&
                $urandom_range(99) >= tx_idle_pct) begin
                w = pending_words.pop_front();
                s_valid <= 1'b1;
                s_action <= w.op;
                s_frame_start <= w.frame_start;
                s_left_in <= w.left_in;
                s_right_in <= w.right_in;
                s_dma_byte <= w.dma_byte;
                s_length <= w.length;
                s_auto_init <= w.auto_init;
                s_speaker_on <= w.speaker_on;
                s_paused <= w.paused;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: track config, predict accepted words, check results, drive ready
    always @(posedge aclk) begin : rx_side
        item_t       w;
        mix_result_t want;
        mix_result_t got;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TIME_CONSTANT: tc_reg = cfg_data[TC_W-1:0];
                    CFG_BLOCK_SIZE:    blk_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                w.op = op_t'(s_action);
                w.frame_start = s_frame_start;
                w.left_in = s_left_in;
                w.right_in = s_right_in;
                w.dma_byte = s_dma_byte;
                w.length = s_length;
                w.auto_init = s_auto_init;
                w.speaker_on = s_speaker_on;
                w.paused = s_paused;
                expected_mix.push_back(predict_mix(w));
            end
            if (m_valid && m_ready) begin
                got = {m_left_out, m_right_out, m_byte_taken, m_irq};
                if (expected_mix.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected result word: left %0d right %0d taken %0b irq %0b",
                             $time, got.left, got.right, got.taken, got.irq);
                end else begin
                    want = expected_mix.pop_front();
                    if (got.left !== want.left) begin
                        mismatches++;
                        $display("%0t left_out: expected %0d, actual %0d",
                                 $time, want.left, got.left);
                    end
                    if (got.right !== want.right) begin
                        mismatches++;
                        $display("%0t right_out: expected %0d, actual %0d",
                                 $time, want.right, got.right);
                    end
                    if (got.taken !== want.taken) begin
                        mismatches++;
                        $display("%0t byte_taken: expected %0b, actual %0b",
                                 $time, want.taken, got.taken);
                    end
                    if (got.irq !== want.irq) begin
                        mismatches++;
                        $display("%0t irq: expected %0b, actual %0b",
                                 $time, want.irq, got.irq);
                    end
                end
            end
            // Hold off for a long stretch when asked, else stall at random
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : sequencer
        logic [TC_W-1:0]    tc_val;
        logic [COUNT_W-1:0] blk_val;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: fastest rate so every active slot takes a byte
        cfg_write(CFG_TIME_CONSTANT, 17'd255);
        cfg_write(CFG_BLOCK_SIZE, 17'd1);
        @(negedge aclk);
        pending_words.push_back(slot_word(1'b0, 16'h7FFF, 16'h8000, 8'hFF));
        pending_words.push_back(rand_word(OP_NOP));
        pending_words.push_back(flags_word(1'b1, 1'b0));
        pending_words.push_back(start_word(17'd3, 1'b0));
        pending_words.push_back(slot_word(1'b1, 16'h7FFF, 16'h8000, 8'hFF));
        pending_words.push_back(slot_word(1'b0, 16'h8000, 16'h7FFF, 8'h00));
        pending_words.push_back(slot_word(1'b0, 16'h0000, 16'hFFFF, 8'h80));
        pending_words.push_back(slot_word(1'b0, 16'h1234, 16'h5678, 8'h55));
        pending_words.push_back(start_word(17'd2, 1'b1));
        pending_words.push_back(slot_word(1'b0, 16'h0001, 16'hFFFE, 8'hAA));
        pending_words.push_back(slot_word(1'b1, 16'h7FFF, 16'h8000, 8'h01));
        pending_words.push_back(slot_word(1'b0, 16'h8000, 16'h7FFF, 8'hFE));
        pending_words.push_back(slot_word(1'b0, 16'h0000, 16'h0000, 8'h7F));
        pending_words.push_back(flags_word(1'b1, 1'b1));
        pending_words.push_back(slot_word(1'b0, 16'h4000, 16'hC000, 8'h81));
        pending_words.push_back(slot_word(1'b1, 16'h7FFF, 16'h8000, 8'hFF));
        pending_words.push_back(flags_word(1'b0, 1'b0));
        pending_words.push_back(slot_word(1'b1, 16'h8000, 16'h7FFF, 8'h00));
        pending_words.push_back(flags_word(1'b1, 1'b0));
        pending_words.push_back(start_word(17'd0, 1'b0));
        pending_words.push_back(slot_word(1'b1, 16'h0F0F, 16'hF0F0, 8'hFF));
        pending_words.push_back(start_word(17'h10000, 1'b0));
        pending_words.push_back(slot_word(1'b1, 16'hFFFF, 16'h0000, 8'h00));
        wait_drained();

        // Zero block size: the reload of zero wraps on the next byte
        cfg_write(CFG_BLOCK_SIZE, 17'd0);
        @(negedge aclk);
        pending_words.push_back(start_word(17'd1, 1'b1));
        pending_words.push_back(slot_word(1'b1, 16'h7FFF, 16'h8000, 8'hC3));
        pending_words.push_back(slot_word(1'b0, 16'h8000, 16'h7FFF, 8'h3C));
        wait_drained();

        // Random phases, each with its own rate and block size; phases 1 to 3 each set their own idling pattern
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin tc_val = 8'd0;   blk_val = 17'h10000; end
                1: begin tc_val = 8'd255; blk_val = COUNT_W'($urandom_range(1, 8)); end
                default: begin
                    tc_val = TC_W'($urandom);
                    blk_val = COUNT_W'($urandom_range(1, 40));
                end
            endcase
            cfg_write(CFG_TIME_CONSTANT, {9'd0, tc_val});
            cfg_write(CFG_BLOCK_SIZE, blk_val);
            @(negedge aclk);
            case (p)
                1: begin tx_idle_pct = 81; rx_stall_pct = 0; end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
                3: begin tx_idle_pct = 28; rx_stall_pct = 28; end
                default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
            endcase
            gen_traffic(100);
            if (p == 4) begin
                // Hold off the result side so the block backs up
                hold_token++;
                while (pending_words.size() > 40) @(negedge aclk);
                // Pause the sender until every result is back
                tx_pause = 1'b1;
                while (s_valid || expected_mix.size() != 0) @(negedge aclk);
                tx_pause = 1'b0;
            end
            wait_drained();
        end

        repeat (5) @(negedge aclk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
